// ===== design/cda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants for the calendar date adder
// Field widths, action codes, datapath operations, the controller state
// type and the reciprocal constants used for division by 12 and by 100.
// ----------------------------------------------------------------------------
package cda_pkg;

    // Field widths.
    localparam int YEAR_W  = 16;
    localparam int AMT_W   = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // Remaining-day counter and the sum of day and remainder.
    localparam int REM_W = AMT_W + 1;
    localparam int SUM_W = REM_W + 1;

    // Month arithmetic: t = (month - 1) + amount, quotient by 12 through a
    // reciprocal multiply that is exact for every t below 2**(AMT_W + 1).
    localparam int MT_W        = AMT_W + 1;
    localparam int MON_SHIFT   = AMT_W + 5;
    localparam int MON_RECIP   = (2 ** MON_SHIFT) / 12 + 1;
    localparam int MON_RECIP_W = AMT_W + 2;
    localparam int MON_PROD_W  = MT_W + MON_RECIP_W;
    localparam int MON_Q_W     = MON_PROD_W - MON_SHIFT;

    // Leap rule: quotient by 100 through a reciprocal multiply, exact for
    // every year below 2**YEAR_W.
    localparam int LEAP_SHIFT   = YEAR_W + 7;
    localparam int LEAP_RECIP   = (2 ** LEAP_SHIFT) / 100 + 1;
    localparam int LEAP_RECIP_W = YEAR_W + 1;
    localparam int LEAP_PROD_W  = YEAR_W + LEAP_RECIP_W;
    localparam int LEAP_Q_W     = LEAP_PROD_W - LEAP_SHIFT;

    // Reset date.
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // Action codes of an input item.
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_DAYS   = 2'd1,
        ACT_MONTHS = 2'd2,
        ACT_YEARS  = 2'd3
    } action_t;

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_YEARS,
        OP_MON_MUL,
        OP_MON_APPLY,
        OP_LEAP_MUL,
        OP_LEAP_SET,
        OP_DAY_STEP,
        OP_OUT_WRITE
    } dp_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MON_APPLY,
        S_LEAP_MUL,
        S_LEAP_SET,
        S_DAY_STEP,
        S_FINISH
    } state_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    day_done;
        logic    year_roll;
    } dp_status_t;

    // Length of a month given the leap flag of its year.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                MONTH_FEB:                 len = leap ? DAY_W'(29) : DAY_W'(28);
                4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
                default:                   len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

endpackage

// ===== design/cda_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_datapath: date registers and arithmetic of the calendar date adder
// Holds the current date, the captured item, the leap flag, the product
// registers of the two reciprocal multiplies and the result registers.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cda_pkg::dp_op_t                   op,
    output cda_pkg::dp_status_t               status,
    input  logic [1:0]                        action,
    input  logic [cda_pkg::AMT_W-1:0]         amount,
    input  logic [cda_pkg::YEAR_W-1:0]        load_year,
    input  logic [cda_pkg::MONTH_W-1:0]       load_month,
    input  logic [cda_pkg::DAY_W-1:0]         load_day,
    output logic [cda_pkg::YEAR_W-1:0]        cur_year,
    output logic [cda_pkg::MONTH_W-1:0]       cur_month,
    output logic [cda_pkg::DAY_W-1:0]         cur_day,
    output logic                              year_wrapped
);

    // Date state.
    logic [cda_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [cda_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cda_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic                        wrap_reg,  wrap_next;
    logic                        leap_reg,  leap_next;

    // Captured item.
    cda_pkg::action_t             act_reg,   act_next;
    logic [cda_pkg::AMT_W-1:0]   amt_reg,   amt_next;
    logic [cda_pkg::YEAR_W-1:0]  ldy_reg,   ldy_next;
    logic [cda_pkg::MONTH_W-1:0] ldm_reg,   ldm_next;
    logic [cda_pkg::DAY_W-1:0]   ldd_reg,   ldd_next;

    // Working registers.
    logic [cda_pkg::REM_W-1:0]       rem_reg,  rem_next;
    logic [cda_pkg::MON_PROD_W-1:0]  mprod_reg, mprod_next;
    logic [cda_pkg::LEAP_PROD_W-1:0] lprod_reg, lprod_next;

    // Result registers.
    logic [cda_pkg::YEAR_W-1:0]  oy_reg, oy_next;
    logic [cda_pkg::MONTH_W-1:0] om_reg, om_next;
    logic [cda_pkg::DAY_W-1:0]   od_reg, od_next;
    logic                        ow_reg, ow_next;

    // Month arithmetic terms.
    logic [cda_pkg::MT_W-1:0]    mon_t;
    logic [cda_pkg::MON_Q_W-1:0] mon_q;
    logic [cda_pkg::MT_W-1:0]    mon_q_ext;
    logic [cda_pkg::MT_W-1:0]    mon_r;
    logic [cda_pkg::YEAR_W:0]    mon_ysum;
    logic [cda_pkg::YEAR_W:0]    add_ysum;

    // Leap rule terms.
    logic [cda_pkg::LEAP_Q_W-1:0] cent_q;
    logic [cda_pkg::YEAR_W-1:0]   cent_q_ext;
    logic [cda_pkg::YEAR_W-1:0]   cent_r;

    // Day walk terms.
    logic [cda_pkg::DAY_W-1:0]  len;
    logic [cda_pkg::SUM_W-1:0]  day_sum;
    logic                       fits;

    // Clamped load values.
    logic [cda_pkg::MONTH_W-1:0] ld_month;
    logic [cda_pkg::DAY_W-1:0]   ld_day;

    // Quotient and remainder of t by 12, t taken from the current month.
    always_comb
    begin
        mon_t     = cda_pkg::MT_W'(month_reg - cda_pkg::MONTH_W'(1))
                    + cda_pkg::MT_W'(amt_reg);
        mon_q     = mprod_reg[cda_pkg::MON_PROD_W-1:cda_pkg::MON_SHIFT];
        mon_q_ext = cda_pkg::MT_W'(mon_q);
        mon_r     = mon_t - (mon_q_ext << 3) - (mon_q_ext << 2);
        mon_ysum  = {1'b0, year_reg} + (cda_pkg::YEAR_W + 1)'(mon_q);
        add_ysum  = {1'b0, year_reg} + (cda_pkg::YEAR_W + 1)'(amt_reg);
    end

    // Century quotient and remainder of the year.
    always_comb
    begin
        cent_q     = lprod_reg[cda_pkg::LEAP_PROD_W-1:cda_pkg::LEAP_SHIFT];
        cent_q_ext = cda_pkg::YEAR_W'(cent_q);
        cent_r     = year_reg - (cent_q_ext << 6) - (cent_q_ext << 5) - (cent_q_ext << 2);
    end

    // One month of the day walk.
    always_comb
    begin
        len     = cda_pkg::month_len(month_reg, leap_reg);
        day_sum = cda_pkg::SUM_W'(day_reg) + cda_pkg::SUM_W'(rem_reg);
        fits    = (day_sum <= cda_pkg::SUM_W'(len));
    end

    // Load clamping.
    always_comb
    begin
        ld_month = ldm_reg;
        if (ldm_reg == '0)
        begin
            ld_month = cda_pkg::MONTH_W'(1);
        end
        else if (ldm_reg > cda_pkg::MONTH_DEC)
        begin
            ld_month = cda_pkg::MONTH_DEC;
        end
        ld_day = (ldd_reg == '0) ? cda_pkg::DAY_W'(1) : ldd_reg;
    end

    assign status.action    = act_reg;
    assign status.day_done  = fits;
    assign status.year_roll = !fits && (month_reg == cda_pkg::MONTH_DEC);

    // Next-state logic for the operation requested by the controller.
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        wrap_next  = wrap_reg;
        leap_next  = leap_reg;
        act_next   = act_reg;
        amt_next   = amt_reg;
        ldy_next   = ldy_reg;
        ldm_next   = ldm_reg;
        ldd_next   = ldd_reg;
        rem_next   = rem_reg;
        mprod_next = mprod_reg;
        lprod_next = lprod_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        ow_next    = ow_reg;
        case (op)
            cda_pkg::OP_CAPTURE:
            begin
                act_next  = cda_pkg::action_t'(action);
                amt_next  = amount;
                ldy_next  = load_year;
                ldm_next  = load_month;
                ldd_next  = load_day;
                wrap_next = 1'b0;
                rem_next  = cda_pkg::REM_W'(amount);
            end
            cda_pkg::OP_LOAD:
            begin
                year_next  = ldy_reg;
                month_next = ld_month;
                day_next   = ld_day;
            end
            cda_pkg::OP_YEARS:
            begin
                year_next = add_ysum[cda_pkg::YEAR_W-1:0];
                wrap_next = add_ysum[cda_pkg::YEAR_W];
            end
            cda_pkg::OP_MON_MUL:
            begin
                mprod_next = cda_pkg::MON_PROD_W'(mon_t)
                             * cda_pkg::MON_PROD_W'(cda_pkg::MON_RECIP);
            end
            cda_pkg::OP_MON_APPLY:
            begin
                year_next  = mon_ysum[cda_pkg::YEAR_W-1:0];
                wrap_next  = mon_ysum[cda_pkg::YEAR_W];
                month_next = mon_r[cda_pkg::MONTH_W-1:0] + cda_pkg::MONTH_W'(1);
            end
            cda_pkg::OP_LEAP_MUL:
            begin
                lprod_next = cda_pkg::LEAP_PROD_W'(year_reg)
                             * cda_pkg::LEAP_PROD_W'(cda_pkg::LEAP_RECIP);
            end
            cda_pkg::OP_LEAP_SET:
            begin
                // Divisible by 4, except by 100, unless by 400.
                leap_next = (year_reg[1:0] == 2'b00)
                            && ((cent_r != '0) || (cent_q[1:0] == 2'b00));
            end
            cda_pkg::OP_DAY_STEP:
            begin
                if (fits)
                begin
                    day_next = day_sum[cda_pkg::DAY_W-1:0];
                end
                else
                begin
                    rem_next = cda_pkg::REM_W'(day_sum - cda_pkg::SUM_W'(len)
                                               - cda_pkg::SUM_W'(1));
                    day_next = cda_pkg::DAY_W'(1);
                    if (month_reg == cda_pkg::MONTH_DEC)
                    begin
                        month_next = cda_pkg::MONTH_W'(1);
                        year_next  = year_reg + cda_pkg::YEAR_W'(1);
                        if (year_reg == '1)
                        begin
                            wrap_next = 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + cda_pkg::MONTH_W'(1);
                    end
                end
            end
            cda_pkg::OP_OUT_WRITE:
            begin
                oy_next = year_reg;
                om_next = month_reg;
                od_next = day_reg;
                ow_next = wrap_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Date state, reset to the start date.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= cda_pkg::RESET_YEAR;
            month_reg <= cda_pkg::RESET_MONTH;
            day_reg   <= cda_pkg::RESET_DAY;
            wrap_reg  <= 1'b0;
            leap_reg  <= 1'b1;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            wrap_reg  <= wrap_next;
            leap_reg  <= leap_next;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        amt_reg   <= amt_next;
        ldy_reg   <= ldy_next;
        ldm_reg   <= ldm_next;
        ldd_reg   <= ldd_next;
        rem_reg   <= rem_next;
        mprod_reg <= mprod_next;
        lprod_reg <= lprod_next;
        oy_reg    <= oy_next;
        om_reg    <= om_next;
        od_reg    <= od_next;
        ow_reg    <= ow_next;
    end

    assign cur_year     = oy_reg;
    assign cur_month    = om_reg;
    assign cur_day      = od_reg;
    assign year_wrapped = ow_reg;

    // The kept month always stays a real month.
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg != '0) && (month_reg <= cda_pkg::MONTH_DEC))
        else $error("month register left the range of months");

    // The kept day of month is never zero.
    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (day_reg != '0))
        else $error("day register holds day zero");

    // A day step that does not fit always restarts the day at one.
    a_day_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (op == cda_pkg::OP_DAY_STEP) && !fits |=> (day_reg == cda_pkg::DAY_W'(1)))
        else $error("day walk did not restart the day of month");

endmodule

// ===== design/cda_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_ctrl: sequencer of the calendar date adder
// Accepts an item, steps the datapath through the action and hands the
// result to the output register when that register is free.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output cda_pkg::dp_op_t     op,
    input  cda_pkg::dp_status_t status
);

    cda_pkg::state_t state_reg, state_next;
    logic            ovalid_reg, ovalid_next;

    // Next state, datapath operation and output valid.
    always_comb
    begin
        state_next  = state_reg;
        op          = cda_pkg::OP_NONE;
        in_ready    = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        case (state_reg)
            cda_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = cda_pkg::OP_CAPTURE;
                    state_next = cda_pkg::S_DISPATCH;
                end
            end
            cda_pkg::S_DISPATCH:
            begin
                case (status.action)
                    cda_pkg::ACT_LOAD:
                    begin
                        op         = cda_pkg::OP_LOAD;
                        state_next = cda_pkg::S_FINISH;
                    end
                    cda_pkg::ACT_YEARS:
                    begin
                        op         = cda_pkg::OP_YEARS;
                        state_next = cda_pkg::S_FINISH;
                    end
                    cda_pkg::ACT_MONTHS:
                    begin
                        op         = cda_pkg::OP_MON_MUL;
                        state_next = cda_pkg::S_MON_APPLY;
                    end
                    default:
                    begin
                        op         = cda_pkg::OP_LEAP_MUL;
                        state_next = cda_pkg::S_LEAP_SET;
                    end
                endcase
            end
            cda_pkg::S_MON_APPLY:
            begin
                op         = cda_pkg::OP_MON_APPLY;
                state_next = cda_pkg::S_FINISH;
            end
            cda_pkg::S_LEAP_MUL:
            begin
                op         = cda_pkg::OP_LEAP_MUL;
                state_next = cda_pkg::S_LEAP_SET;
            end
            cda_pkg::S_LEAP_SET:
            begin
                op         = cda_pkg::OP_LEAP_SET;
                state_next = cda_pkg::S_DAY_STEP;
            end
            cda_pkg::S_DAY_STEP:
            begin
                // A step into January needs the leap flag of the new year.
                op = cda_pkg::OP_DAY_STEP;
                if (status.day_done)
                begin
                    state_next = cda_pkg::S_FINISH;
                end
                else if (status.year_roll)
                begin
                    state_next = cda_pkg::S_LEAP_MUL;
                end
            end
            cda_pkg::S_FINISH:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    op          = cda_pkg::OP_OUT_WRITE;
                    ovalid_next = 1'b1;
                    state_next  = cda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cda_pkg::S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cda_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    // An accepted item always goes to dispatch next.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == cda_pkg::S_DISPATCH))
        else $error("accepted item was not dispatched");

    // A finished day walk moves on to the result stage.
    a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cda_pkg::S_DAY_STEP) && status.day_done
        |=> (state_reg == cda_pkg::S_FINISH))
        else $error("day walk did not finish");

    // A result waits while the previous one is still held by the receiver.
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cda_pkg::S_FINISH) && out_valid && !out_ready
        |=> (state_reg == cda_pkg::S_FINISH) && out_valid)
        else $error("result overwrote a result not yet taken");

endmodule

// ===== design/calendar_date_adder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_adder_unit: Gregorian date keeper and adder
// Keeps a date and applies one load or add action per item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item: an action code
//   with an amount or a date to load. The output channel (out_valid/out_ready)
//   returns one item per input item: the resulting date and a year wrap flag.
//   One item is worked on at a time; the next item is taken in the cycle
//   after the current one has been handed to the output register.
//   Steps from acceptance to out_valid: a load or an add of years is applied
//   at dispatch, an add of months by a reciprocal multiply, then an apply.
//   An add of days sets the leap flag (multiply, then set), then walks one
//   month per cycle, refreshing the leap flag the same way at each year
//   boundary crossed. Each result is then written to the output register.
//   Reset sets the date to 1 January 2000 and clears the output valid.
//   If the receiver stalls, the result stays in the output register; one
//   further item may be accepted and worked, and its result waits until the
//   held result is taken.
// ----------------------------------------------------------------------------
module calendar_date_adder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [cda_pkg::AMT_W-1:0]     amount,
    input  logic [cda_pkg::YEAR_W-1:0]    load_year,
    input  logic [cda_pkg::MONTH_W-1:0]   load_month,
    input  logic [cda_pkg::DAY_W-1:0]     load_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cda_pkg::YEAR_W-1:0]    cur_year,
    output logic [cda_pkg::MONTH_W-1:0]   cur_month,
    output logic [cda_pkg::DAY_W-1:0]     cur_day,
    output logic                          year_wrapped
);

    cda_pkg::dp_op_t     op;
    cda_pkg::dp_status_t status;

    // Sequencer.
    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (op),
        .status    (status)
    );

    // Date registers and arithmetic.
    cda_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .action       (action),
        .amount       (amount),
        .load_year    (load_year),
        .load_month   (load_month),
        .load_day     (load_day),
        .cur_year     (cur_year),
        .cur_month    (cur_month),
        .cur_day      (cur_day),
        .year_wrapped (year_wrapped)
    );

endmodule

// ===== verif/tb_calendar_date_adder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_adder_unit: self-checking bench for the date adder
// Drives load and add items through the valid/ready input, keeps its own
// calendar model of the kept date, and checks every result item field by
// field in order. A directed table covers the edges of the calendar, then
// random items run in three idling phases, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_calendar_date_adder_unit;

    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEMS_PER_PHASE = 82;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTS    = 60;

    // One result item: the date after the item and the wrap flag.
    typedef struct packed {
        logic [cda_pkg::YEAR_W-1:0]  year;
        logic [cda_pkg::MONTH_W-1:0] month;
        logic [cda_pkg::DAY_W-1:0]   day;
        logic                        wrapped;
    } date_t;

    // One input item, with an optional hand-written expected date.
    typedef struct packed {
        cda_pkg::action_t            act;
        logic [cda_pkg::AMT_W-1:0]   amt;
        logic [cda_pkg::YEAR_W-1:0]  ly;
        logic [cda_pkg::MONTH_W-1:0] lm;
        logic [cda_pkg::DAY_W-1:0]   ld;
        bit                          typed;
        date_t                       want;
    } date_item_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    action;
    logic [cda_pkg::AMT_W-1:0]     amount;
    logic [cda_pkg::YEAR_W-1:0]    load_year;
    logic [cda_pkg::MONTH_W-1:0]   load_month;
    logic [cda_pkg::DAY_W-1:0]     load_day;
    logic                          out_valid;
    logic                          out_ready;
    logic [cda_pkg::YEAR_W-1:0]    cur_year;
    logic [cda_pkg::MONTH_W-1:0]   cur_month;
    logic [cda_pkg::DAY_W-1:0]     cur_day;
    logic                          year_wrapped;

    // Calendar model of the date kept by the block.
    logic [cda_pkg::YEAR_W-1:0]    cal_year;
    logic [cda_pkg::MONTH_W-1:0]   cal_month;
    logic [cda_pkg::DAY_W-1:0]     cal_day;

    date_t                pending_dates[$];
    date_item_t           directed_items[$];
    date_t                front_date;

    int unsigned          error_count;
    int unsigned          results_checked;
    int unsigned          items_sent;
    int unsigned          wraps_predicted;
    int unsigned          action_count [4];
    int unsigned          cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    bit                   hold_output;
    int unsigned          holds_done;

    calendar_date_adder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .amount       (amount),
        .load_year    (load_year),
        .load_month   (load_month),
        .load_day     (load_day),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cur_year     (cur_year),
        .cur_month    (cur_month),
        .cur_day      (cur_day),
        .year_wrapped (year_wrapped)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gregorian leap rule, including the 400-year exception.
    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Adds years to the model date; returns 1 when the year wraps.
    function automatic bit bump_years(input int unsigned inc);
        int unsigned sum;
        sum = int'(cal_year) + inc;
        cal_year = sum[cda_pkg::YEAR_W-1:0];
        return (sum >> cda_pkg::YEAR_W) != 0;
    endfunction

    // Adds months, carrying whole years; the day is left alone.
    function automatic bit bump_months(input int unsigned inc);
        int unsigned t;
        bit          w;
        t = int'(cal_month) - 1 + inc;
        w = bump_years(t / 12);
        cal_month = cda_pkg::MONTH_W'(t % 12 + 1);
        return w;
    endfunction

    // Walks forward one month at a time; an oversized day is rolled first.
    function automatic bit step_days(input int unsigned inc);
        int unsigned left;
        int unsigned len;
        bit          w;
        w = 1'b0;
        left = inc;
        len = month_days(cal_year, cal_month);
        while (int'(cal_day) + left > len)
        begin
            left = int'(cal_day) + left - len - 1;
            cal_day = cda_pkg::DAY_W'(1);
            if (bump_months(1))
                w = 1'b1;
            len = month_days(cal_year, cal_month);
        end
        cal_day = cda_pkg::DAY_W'(int'(cal_day) + left);
        return w;
    endfunction

    // Applies one item to the model and returns the date it should produce.
    function automatic date_t apply_item(input date_item_t it);
        date_t                       res;
        logic [cda_pkg::MONTH_W-1:0] m;
        logic [cda_pkg::DAY_W-1:0]   d;
        bit                          w;
        w = 1'b0;
        case (it.act)
            cda_pkg::ACT_LOAD:
            begin
                m = it.lm;
                d = it.ld;
                if (m == 0)
                    m = cda_pkg::MONTH_W'(1);
                if (m > cda_pkg::MONTH_DEC)
                    m = cda_pkg::MONTH_DEC;
                if (d == 0)
                    d = cda_pkg::DAY_W'(1);
                cal_year  = it.ly;
                cal_month = m;
                cal_day   = d;
            end
            cda_pkg::ACT_DAYS:   w = step_days(it.amt);
            cda_pkg::ACT_MONTHS: w = bump_months(it.amt);
            default:             w = bump_years(it.amt);
        endcase
        res.year    = cal_year;
        res.month   = cal_month;
        res.day     = cal_day;
        res.wrapped = w;
        return res;
    endfunction

    // Builds one row of the directed table.
    function automatic date_item_t table_row(input cda_pkg::action_t a,
                                             input int unsigned amt,
                                             input int unsigned y, input int unsigned m,
                                             input int unsigned d, input bit typed,
                                             input int unsigned wy, input int unsigned wm,
                                             input int unsigned wd, input bit ww);
        date_item_t it;
        it.act   = a;
        it.amt   = cda_pkg::AMT_W'(amt);
        it.ly    = cda_pkg::YEAR_W'(y);
        it.lm    = cda_pkg::MONTH_W'(m);
        it.ld    = cda_pkg::DAY_W'(d);
        it.typed = typed;
        it.want  = '{year: cda_pkg::YEAR_W'(wy), month: cda_pkg::MONTH_W'(wm),
                     day: cda_pkg::DAY_W'(wd), wrapped: ww};
        return it;
    endfunction

    // Random item: mostly valid dates and modest day counts, with rare
    // full-range day adds, years near the top and out-of-range load fields.
    function automatic date_item_t random_item();
        date_item_t  it;
        int unsigned pick;
        int unsigned size_pick;
        it = '0;
        it.amt = cda_pkg::AMT_W'($urandom_range(0, 65535));
        it.ly  = cda_pkg::YEAR_W'($urandom_range(0, 65535));
        it.lm  = cda_pkg::MONTH_W'($urandom_range(0, 15));
        it.ld  = cda_pkg::DAY_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            it.act = cda_pkg::ACT_LOAD;
            if ($urandom_range(0, 3) == 0)
                it.ly = cda_pkg::YEAR_W'(65535 - $urandom_range(0, 3));
            if ($urandom_range(0, 9) != 0)
                it.lm = cda_pkg::MONTH_W'($urandom_range(1, 12));
            if ($urandom_range(0, 4) != 0 && it.lm >= 1 && it.lm <= 12)
                it.ld = cda_pkg::DAY_W'($urandom_range(1, month_days(it.ly, it.lm)));
        end
        else if (pick < 60)
        begin
            it.act = cda_pkg::ACT_DAYS;
            if (size_pick < 80)
                it.amt = cda_pkg::AMT_W'($urandom_range(0, 400));
            else if (size_pick < 95)
                it.amt = cda_pkg::AMT_W'($urandom_range(0, 4000));
        end
        else if (pick < 80)
        begin
            it.act = cda_pkg::ACT_MONTHS;
            if (size_pick < 50)
                it.amt = cda_pkg::AMT_W'($urandom_range(0, 30));
        end
        else
        begin
            it.act = cda_pkg::ACT_YEARS;
            if (size_pick < 50)
                it.amt = cda_pkg::AMT_W'($urandom_range(0, 10));
        end
        return it;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR result %0d at %0t: %s", results_checked, $realtime, what);
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    // Offers one item, after a random gap, and records its expected date
    // at the edge where it is accepted.
    task automatic offer_item(input date_item_t it);
        date_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = it.act;
        amount     = it.amt;
        load_year  = it.ly;
        load_month = it.lm;
        load_day   = it.ld;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_item(it);
        if (it.typed)
            pending_dates.push_back(it.want);
        else
            pending_dates.push_back(predicted);
        items_sent++;
        action_count[it.act]++;
        if (predicted.wrapped)
            wraps_predicted++;
        @(negedge clk);
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                holds_done++;
            end
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checking against the oldest expected date.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
                report_mismatch("result arrived with no item pending");
            else
            begin
                front_date = pending_dates.pop_front();
                check_field("cur_year", cur_year, front_date.year);
                check_field("cur_month", cur_month, front_date.month);
                check_field("cur_day", cur_day, front_date.day);
                check_field("year_wrapped", year_wrapped, front_date.wrapped);
            end
            results_checked++;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_calendar_date_adder_unit: done, errors");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = cda_pkg::ACT_LOAD;
        amount        = '0;
        load_year     = '0;
        load_month    = '0;
        load_day      = '0;
        hold_output   = 1'b0;
        holds_done    = 0;
        error_count   = 0;
        results_checked = 0;
        items_sent    = 0;
        wraps_predicted = 0;
        action_count  = '{default: 0};
        cal_year      = cda_pkg::RESET_YEAR;
        cal_month     = cda_pkg::RESET_MONTH;
        cal_day       = cda_pkg::RESET_DAY;
        send_idle_pct = 25;
        recv_idle_pct = 52;

        // Directed table: action, amount, load date, then the expected date where obvious.
        directed_items.push_back(table_row(cda_pkg::ACT_YEARS, 0, 0, 0, 0,
                                           1, 2000, 1, 1, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 65535, 65535, 12, 31,
                                           1, 65535, 12, 31, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 1, 0, 0, 0,
                                           1, 0, 1, 1, 1));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 0, 0, 0,
                                           1, 0, 1, 1, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2023, 15, 31,
                                           1, 2023, 12, 31, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2023, 13, 5,
                                           1, 2023, 12, 5, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2023, 2, 31,
                                           1, 2023, 2, 31, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 0, 0, 0, 0,
                                           1, 2023, 3, 3, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2024, 2, 29,
                                           1, 2024, 2, 29, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_YEARS, 1, 0, 0, 0,
                                           1, 2025, 2, 29, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 0, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 1900, 2, 28,
                                           1, 1900, 2, 28, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 1, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2000, 2, 28,
                                           1, 2000, 2, 28, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 1, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2000, 1, 31,
                                           1, 2000, 1, 31, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_MONTHS, 1, 0, 0, 0,
                                           1, 2000, 2, 31, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_MONTHS, 65535, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_YEARS, 65535, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 65535, 1, 1,
                                           1, 65535, 1, 1, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_YEARS, 1, 0, 0, 0,
                                           1, 0, 1, 1, 1));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 65535, 0, 0, 0,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 65535, 12, 1,
                                           1, 65535, 12, 1, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_MONTHS, 1, 0, 0, 0,
                                           1, 0, 1, 1, 1));
        directed_items.push_back(table_row(cda_pkg::ACT_LOAD, 0, 2100, 2, 28,
                                           0, 0, 0, 0, 0));
        directed_items.push_back(table_row(cda_pkg::ACT_DAYS, 1, 0, 0, 0,
                                           0, 0, 0, 0, 0));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_items[i])
            offer_item(directed_items[i]);

        // Random items in three idling phases; the last one opens with a
        // long output hold-off while the input keeps pushing.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_output   = 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                offer_item(random_item());
        end
        in_valid = 1'b0;

        // Drain, then give any stray result time to show up.
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d items: %0d loads, %0d day adds, %0d month adds, %0d year adds.",
                 items_sent, action_count[cda_pkg::ACT_LOAD],
                 action_count[cda_pkg::ACT_DAYS], action_count[cda_pkg::ACT_MONTHS],
                 action_count[cda_pkg::ACT_YEARS]);
        $display("Checked %0d results, %0d with a year wrap, %0d long output hold-off(s).",
                 results_checked, wraps_predicted, holds_done);
        if (error_count == 0 && pending_dates.size() == 0)
            $display("tb_calendar_date_adder_unit: done, clean");
        else
            $display("tb_calendar_date_adder_unit: done, errors");
        $finish;
    end

endmodule
